>>> hw/rtl/brf_pkg.sv
// Shared types and constants for the byte ring FIFO with burst reports.
package brf_pkg;

    localparam int DATA_W    = 8;
    localparam int CNT_W     = 7;
    localparam int CMD_W     = 2;
    localparam int KIND_W    = 2;
    localparam int DEPTH_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READALL = 2'd2;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] data_byte;
        logic              burst_last;
        logic [CNT_W-1:0]  request_length;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic pop;
        logic stream_sel;
    } t_ctl_cmd;

    typedef struct packed {
        logic start_report;
        logic start_stream;
        logic stream_last;
    } t_dp_status;

endpackage

>>> hw/rtl/brf_ctrl.sv
// Request sequencer: accepts requests and steps report and byte-stream results.
module brf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  brf_pkg::t_dp_status i_status,
    output brf_pkg::t_ctl_cmd   o_cmd
);
    import brf_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REPORT = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_REPORT) || (r_state == ST_STREAM);
    assign accept      = i_in_valid && o_in_ready;

    assign o_cmd.accept     = accept;
    assign o_cmd.pop        = (r_state == ST_STREAM) && i_out_ready;
    assign o_cmd.stream_sel = (r_state == ST_STREAM);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    priority if (i_status.start_report) begin
                        n_state = ST_REPORT;
                    end else if (i_status.start_stream) begin
                        n_state = ST_STREAM;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_REPORT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_STREAM: begin
                if (i_out_ready && i_status.stream_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/brf_datapath.sv
// Ring store, pointers, fill and burst counters, and result payload.
module brf_datapath #(
    parameter int STORE_DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  brf_pkg::t_in_item         i_in_item,
    input  logic                      i_cfg_we,
    input  logic [brf_pkg::CNT_W-1:0] i_cfg_data,
    input  brf_pkg::t_ctl_cmd         i_cmd,
    output brf_pkg::t_dp_status       o_status,
    output brf_pkg::t_out_item        o_out_item
);
    import brf_pkg::*;

    localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [CNT_W-1:0]  r_burst, n_burst;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [CNT_W-1:0]  r_remain, n_remain;
    logic [CNT_W-1:0]  r_total, n_total;
    logic [KIND_W-1:0] r_rep_kind, n_rep_kind;
    logic [CNT_W-1:0]  r_rep_count, n_rep_count;
    logic [DATA_W-1:0] r_rd_data;

    logic [CNT_W-1:0]  head_inc;
    logic [CNT_W-1:0]  tail_inc;
    logic [PTR_W-1:0]  head_wrap;
    logic [PTR_W-1:0]  tail_wrap;
    logic [CNT_W-1:0]  burst_upd;
    logic [CNT_W-1:0]  want;
    logic [CNT_W-1:0]  take;
    logic [CNT_W-1:0]  cap_clamp;
    logic              is_read;
    logic              wr_en;

    assign head_inc  = CNT_W'(r_head) + 1'b1;
    assign tail_inc  = CNT_W'(r_tail) + 1'b1;
    assign head_wrap = (head_inc >= r_cap) ? '0 : head_inc[PTR_W-1:0];
    assign tail_wrap = (tail_inc >= r_cap) ? '0 : tail_inc[PTR_W-1:0];
    assign burst_upd = (r_burst != '1) ? r_burst + 1'b1 : r_burst;

    assign is_read = (i_in_item.command == CMD_READ) || (i_in_item.command == CMD_READALL);

    always_comb begin
        want = (i_in_item.command == CMD_READ) ? i_in_item.request_length : r_fill;
        take = (want < r_fill) ? want : r_fill;
        if ((i_in_item.command == CMD_READALL) && (i_in_item.request_length < r_fill)) begin
            take = '0;
        end
    end

    always_comb begin
        cap_clamp = i_cfg_data;
        if (i_cfg_data == '0) begin
            cap_clamp = CNT_W'(1);
        end else if (i_cfg_data > DEPTH_CNT) begin
            cap_clamp = DEPTH_CNT;
        end
    end

    assign o_status.start_report =
        ((i_in_item.command == CMD_WRITE) && i_in_item.burst_last) || (is_read && (take == '0));
    assign o_status.start_stream = is_read && (take != '0);
    assign o_status.stream_last  = (r_remain == CNT_W'(1));

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_burst     = r_burst;
        n_cap       = r_cap;
        n_remain    = r_remain;
        n_total     = r_total;
        n_rep_kind  = r_rep_kind;
        n_rep_count = r_rep_count;
        wr_en       = 1'b0;

        if (i_cmd.accept) begin
            unique case (i_in_item.command)
                CMD_WRITE: begin
                    if (r_fill < r_cap) begin
                        wr_en   = 1'b1;
                        n_tail  = tail_wrap;
                        n_fill  = r_fill + 1'b1;
                        n_burst = burst_upd;
                    end
                    if (i_in_item.burst_last) begin
                        n_rep_kind  = KIND_WRITE;
                        n_rep_count = (r_fill < r_cap) ? burst_upd : r_burst;
                        n_burst     = '0;
                    end
                end
                CMD_READ, CMD_READALL: begin
                    if (take == '0) begin
                        n_rep_kind  = KIND_EMPTY;
                        n_rep_count = '0;
                    end else begin
                        n_remain = take;
                        n_total  = take;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.pop) begin
            n_head   = head_wrap;
            n_remain = r_remain - 1'b1;
            n_fill   = r_fill - 1'b1;
            if (r_fill == CNT_W'(1)) begin
                n_head = '0;
                n_tail = '0;
            end
        end

        if (i_cfg_we && (r_fill == '0)) begin
            n_cap  = cap_clamp;
            n_head = '0;
            n_tail = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_in_item.data_byte;
        end
    end

    // hold the byte at the next head, forwarding a same-cycle write
    always_ff @(posedge i_clk) begin
        if (wr_en && (r_tail == n_head)) begin
            r_rd_data <= i_in_item.data_byte;
        end else begin
            r_rd_data <= mem[n_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
            r_burst  <= '0;
            r_cap    <= DEPTH_CNT;
            r_remain <= '0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_fill   <= n_fill;
            r_burst  <= n_burst;
            r_cap    <= n_cap;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_total     <= n_total;
        r_rep_kind  <= n_rep_kind;
        r_rep_count <= n_rep_count;
    end

    always_comb begin
        if (i_cmd.stream_sel) begin
            o_out_item.kind     = KIND_BYTE;
            o_out_item.data_out = r_rd_data;
            o_out_item.last     = o_status.stream_last;
            o_out_item.count    = o_status.stream_last ? r_total : '0;
        end else begin
            o_out_item.kind     = r_rep_kind;
            o_out_item.data_out = '0;
            o_out_item.last     = 1'b1;
            o_out_item.count    = r_rep_count;
        end
    end

endmodule

>>> hw/rtl/byte_ring_fifo_burst_top.sv
// Byte ring FIFO with burst write reports and length-limited reads.
// Writes: one request per cycle outside reports; a burst report appears the cycle after
// its last byte. Reads: first byte the cycle after the request, then one byte per cycle
// while output is ready (registered read port). Next request after the last result.
// Reset (synchronous, active low): store empty, pointers zero, capacity at full depth.
module byte_ring_fifo_burst_top #(
    parameter int STORE_DEPTH = brf_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  brf_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output brf_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_we,
    input  logic [brf_pkg::CNT_W-1:0] i_cfg_data
);
    import brf_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    brf_datapath #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_item (o_out_item)
    );

endmodule

>>> tb/sv/byte_ring_fifo_burst_top_tb.sv
// Self-checking testbench for the byte ring FIFO with burst reports and clamped reads.
`timescale 1ns / 1ps

module byte_ring_fifo_burst_top_tb;
    import brf_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_SKIP = 2'd3;
    localparam int unsigned BURST_MAX = 127;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_MAX = 50;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_we = 1'b0;
    logic [CNT_W-1:0] i_cfg_data = '0;

    byte_ring_fifo_burst_top #(
        .STORE_DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    t_in_item pending_requests[$];
    t_out_item owed_results[$];

    logic [DATA_W-1:0] ring_mem [STORE_DEPTH];
    int unsigned rd_ptr = 0;
    int unsigned wr_ptr = 0;
    int unsigned level = 0;
    int unsigned burst_cnt = 0;
    int unsigned cap_slots = STORE_DEPTH;

    int cycle_count = 0;
    int mismatches = 0;
    int requests_queued = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int holds_asked = 0;
    int holds_served = 0;

    int gap_left = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out_item result_of(logic [KIND_W-1:0] k, logic [DATA_W-1:0] d,
                                            logic [CNT_W-1:0] c, logic l);
        t_out_item r;
        r.kind = k;
        r.data_out = d;
        r.count = c;
        r.last = l;
        return r;
    endfunction

    function automatic void stream_bytes(int unsigned want);
        int unsigned n;
        n = (want < level) ? want : level;
        if (n == 0) begin
            owed_results.push_back(result_of(KIND_EMPTY, '0, '0, 1'b1));
            return;
        end
        for (int unsigned i = 0; i < n; i++) begin
            owed_results.push_back(result_of(KIND_BYTE, ring_mem[rd_ptr],
                                             (i + 1 == n) ? CNT_W'(n) : '0, i + 1 == n));
            rd_ptr++;
            if (rd_ptr >= cap_slots) rd_ptr = 0;
        end
        level -= n;
        if (level == 0) begin
            rd_ptr = 0;
            wr_ptr = 0;
        end
    endfunction

    function automatic void compute_ring_results(t_in_item req);
        case (req.command)
            CMD_WRITE: begin
                if (level < cap_slots) begin
                    ring_mem[wr_ptr] = req.data_byte;
                    wr_ptr++;
                    if (wr_ptr >= cap_slots) wr_ptr = 0;
                    level++;
                    if (burst_cnt < BURST_MAX) burst_cnt++;
                end
                if (req.burst_last) begin
                    owed_results.push_back(result_of(KIND_WRITE, '0, CNT_W'(burst_cnt), 1'b1));
                    burst_cnt = 0;
                end
            end
            CMD_READ: stream_bytes(32'(req.request_length));
            CMD_READALL: begin
                if (32'(req.request_length) < level)
                    owed_results.push_back(result_of(KIND_EMPTY, '0, '0, 1'b1));
                else
                    stream_bytes(level);
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_capacity(logic [CNT_W-1:0] v);
        if (level != 0) return;
        if (v == 0) cap_slots = 1;
        else if (32'(v) > STORE_DEPTH) cap_slots = STORE_DEPTH;
        else cap_slots = 32'(v);
        rd_ptr = 0;
        wr_ptr = 0;
    endfunction

    task automatic flag_mismatch(string what);
        if (mismatches < PRINT_MAX)
            $display("[cycle %0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic queue_request(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d, logic l,
                                 logic [CNT_W-1:0] n);
        t_in_item req;
        req.command = c;
        req.data_byte = d;
        req.burst_last = l;
        req.request_length = n;
        pending_requests.push_back(req);
        if (c != CMD_SKIP) requests_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || owed_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CNT_W-1:0] v);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_capacity(v);
    endtask

    task automatic queue_random_mix(int n, int unsigned cap);
        int made;
        int unsigned pick;
        int unsigned blen;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                blen = $urandom_range(1, cap + 4);
                for (int unsigned b = 1; b <= blen; b++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        queue_request(CMD_READ, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                                      CNT_W'($urandom_range(0, cap)));
                        made++;
                    end
                    queue_request(CMD_WRITE, DATA_W'($urandom), b == blen,
                                  CNT_W'($urandom));
                    made++;
                end
            end else if (pick < 80) begin
                queue_request(CMD_READ, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              CNT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(65, 127)
                                                                 : $urandom_range(0, cap + 1)));
                made++;
            end else if (pick < 95) begin
                queue_request(CMD_READALL, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              CNT_W'(($urandom_range(0, 7) == 0) ? 127
                                                                 : $urandom_range(0, cap + 2)));
                made++;
            end else begin
                queue_request(CMD_SKIP, DATA_W'($urandom), 1'($urandom_range(0, 1)),
                              CNT_W'($urandom));
            end
        end
        // empty the store so the next capacity write takes effect
        queue_request(CMD_READ, DATA_W'($urandom), 1'b0, 7'd127);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                compute_ring_results(i_in_item);
                requests_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= pending_requests.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                               : $urandom_range(0, 3);
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    2: i_out_ready <= (mode_left % 3 == 0);
                    default: i_out_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                flag_mismatch($sformatf("result with nothing owed: %p", o_out_item));
            end else begin
                want = owed_results.pop_front();
                results_checked++;
                if (o_out_item.kind !== want.kind)
                    flag_mismatch($sformatf("kind %0d, want %0d", o_out_item.kind, want.kind));
                if (o_out_item.data_out !== want.data_out)
                    flag_mismatch($sformatf("data_out %0h, want %0h",
                                            o_out_item.data_out, want.data_out));
                if (o_out_item.count !== want.count)
                    flag_mismatch($sformatf("count %0d, want %0d", o_out_item.count, want.count));
                if (o_out_item.last !== want.last)
                    flag_mismatch($sformatf("last %0b, want %0b", o_out_item.last, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_capacity(7'd3);
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd0);
        queue_request(CMD_READ, 8'hFF, 1'b1, 7'd127);
        queue_request(CMD_READALL, 8'h00, 1'b0, 7'd0);
        queue_request(CMD_WRITE, 8'h00, 1'b0, 7'd0);
        queue_request(CMD_WRITE, 8'hFF, 1'b0, 7'd127);
        queue_request(CMD_WRITE, 8'hA5, 1'b0, 7'd0);
        queue_request(CMD_WRITE, 8'h5A, 1'b1, 7'd0);
        queue_request(CMD_SKIP, 8'hFF, 1'b1, 7'd127);
        // store not empty: capacity write must be dropped
        write_capacity(7'd10);
        queue_request(CMD_READALL, 8'h00, 1'b0, 7'd2);
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd0);
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd1);
        queue_request(CMD_WRITE, 8'h3C, 1'b1, 7'd0);
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd127);
        queue_request(CMD_WRITE, 8'h77, 1'b1, 7'd64);
        queue_request(CMD_READALL, 8'h00, 1'b0, 7'd64);
        queue_request(CMD_READALL, 8'h00, 1'b1, 7'd127);
        queue_request(CMD_WRITE, 8'h01, 1'b0, 7'd0);
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd64);
        queue_request(CMD_WRITE, 8'h02, 1'b1, 7'd0);
        queue_request(CMD_READALL, 8'h00, 1'b0, 7'd1);

        write_capacity(7'd0);
        queue_random_mix(40, 1);

        write_capacity(7'd2);
        queue_random_mix(40, 2);

        // long burst with interleaved reads: accepted count saturates
        write_capacity(7'd127);
        for (int b = 1; b <= 130; b++) begin
            queue_request(CMD_WRITE, DATA_W'($urandom), b == 130, CNT_W'($urandom));
            if (b % 16 == 0) queue_request(CMD_READ, DATA_W'($urandom), 1'b0, 7'd16);
        end
        queue_request(CMD_READ, 8'h00, 1'b0, 7'd127);

        write_capacity(7'd7);
        queue_random_mix(60, 7);
        holds_asked++;

        write_capacity(7'd64);
        queue_random_mix(60, 64);
        holds_asked++;

        write_capacity(7'd20);
        queue_random_mix(50, 20);

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("Covered %0d requests (%0d taken) and %0d results, capacities 1-64,",
                 requests_queued, requests_taken, results_checked);
        $display("with full-store drops, clamped and refused reads, and burst count saturation.");
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, owed_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> byte_ring_fifo_burst_top.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_ctrl.sv
hw/rtl/brf_datapath.sv
hw/rtl/byte_ring_fifo_burst_top.sv
tb/sv/byte_ring_fifo_burst_top_tb.sv
